// ----- sv/kmss_pkg.sv -----
`default_nettype none

package kmss_pkg;

   localparam int MAX_PATTERN_DEF = 64;

   localparam int SYMBOL_W   = 8;
   localparam int SLOT_W     = 6;
   localparam int SEQ_W      = 16;
   localparam int POS_W      = 32;
   localparam int CFG_W      = 7;
   localparam int CSR_INDEX_W = 1;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 48;

   localparam logic [SYMBOL_W-1:0] CASE_OFFSET = 8'd32;

   localparam logic [CSR_INDEX_W-1:0] REG_MISMATCH_LIMIT = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_LENGTH = 1'd1;

   localparam logic MODE_PATTERN  = 1'b0;
   localparam logic MODE_SEQUENCE = 1'b1;

   typedef struct packed {
      logic                shift;
      logic [SYMBOL_W-1:0] pat_data;
   } cell_ctl_type;

   // A lowercase text byte also matches its uppercase pattern byte.
   function automatic logic sym_match(input logic [SYMBOL_W-1:0] p,
                                      input logic [SYMBOL_W-1:0] t);
      logic eq;
      logic folded;
      eq     = (p == t);
      folded = (t >= CASE_OFFSET) && (p == (t - CASE_OFFSET));
      return eq || folded;
   endfunction

endpackage

`default_nettype wire

// ----- sv/kmss_cell.sv -----
`default_nettype none

module kmss_cell (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire kmss_pkg::cell_ctl_type         ctl,
   input  wire logic [kmss_pkg::SYMBOL_W-1:0]  text_in,
   input  wire logic                           pat_we,
   input  wire logic                           active,
   output logic      [kmss_pkg::SYMBOL_W-1:0]  text_out,
   output logic                                miss
);

   logic [kmss_pkg::SYMBOL_W-1:0] tw_ff;
   logic [kmss_pkg::SYMBOL_W-1:0] tw_in;
   logic [kmss_pkg::SYMBOL_W-1:0] pr_ff;
   logic [kmss_pkg::SYMBOL_W-1:0] pr_in;

   always_comb begin
      tw_in = ctl.shift ? text_in : tw_ff;
      pr_in = pat_we ? ctl.pat_data : pr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tw_ff <= '0;
      end else begin
         tw_ff <= tw_in;
      end
   end

   always_ff @(posedge clock) begin
      pr_ff <= pr_in;
   end

   assign text_out = tw_ff;
   assign miss     = active && !kmss_pkg::sym_match(pr_ff, tw_ff);

endmodule

`default_nettype wire

// ----- sv/kmss_sum_tree.sv -----
`default_nettype none

module kmss_sum_tree #(
   parameter int N  = kmss_pkg::MAX_PATTERN_DEF,
   parameter int CW = $clog2(kmss_pkg::MAX_PATTERN_DEF + 1)
) (
   input  wire logic          clock,
   input  wire logic [N-1:0]  bits,
   output logic      [CW-1:0] sum
);

   localparam int LV = (N > 1) ? $clog2(N) : 0;
   localparam int P  = 1 << LV;

   logic [CW-1:0] node_ff [LV+1][P];

   genvar i;
   genvar l;

   for (i = 0; i < P; i++) begin : g_leaf
      if (i < N) begin : g_used
         always_ff @(posedge clock) begin
            node_ff[0][i] <= CW'(bits[i]);
         end
      end else begin : g_pad
         always_ff @(posedge clock) begin
            node_ff[0][i] <= '0;
         end
      end
   end

   for (l = 1; l <= LV; l++) begin : g_level
      for (i = 0; i < (P >> l); i++) begin : g_node
         always_ff @(posedge clock) begin
            node_ff[l][i] <= node_ff[l-1][2*i] + node_ff[l-1][2*i+1];
         end
      end
   end

   assign sum = node_ff[LV][0];

endmodule

`default_nettype wire

// ----- sv/k_mismatch_sequence_search_core.sv -----
`default_nettype none

// The core holds a pattern of up to MAX_PATTERN bytes and scans a stream of
// sequence bytes, reporting every window that lies inside one sequence and
// differs from the pattern in at most mismatch_limit places (a lowercase text
// byte matches its uppercase pattern byte). Hits leave in ascending start
// order. A row of cells holds the text window and the pattern aligned to it;
// all cells compare at once and a registered adder tree counts mismatches.
// A pattern byte load does not hold off the next item. A sequence byte holds
// off the next item until its mismatch count has left the adder tree, and
// longer while a hit waits for the result register to drain. A write to
// pattern_length realigns the pattern cells from the pattern memory, one cell
// a cycle, and holds off items until the last cell has been written.
module k_mismatch_sequence_search_core #(
   parameter int MAX_PATTERN = kmss_pkg::MAX_PATTERN_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // symbol[7:0], pattern_slot[13:8], new_sequence[14], sequence_index[30:15]
   input  wire logic [kmss_pkg::REQ_DATA_W-1:0]     req_tdata,
   // mode[0]
   input  wire logic                                req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // hit_sequence[15:0], hit_position[47:16]
   output logic      [kmss_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [kmss_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [kmss_pkg::CFG_W-1:0]          csr_data
);

   localparam int LV = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 0;
   localparam int PD = LV + 2;
   localparam int CW = $clog2(MAX_PATTERN + 1);
   localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   logic                            mode;
   logic [kmss_pkg::SYMBOL_W-1:0]   sym;
   logic [kmss_pkg::SLOT_W-1:0]     slot;
   logic                            fresh;
   logic [kmss_pkg::SEQ_W-1:0]      seqi;

   assign mode  = req_tuser;
   assign sym   = req_tdata[7:0];
   assign slot  = req_tdata[13:8];
   assign fresh = req_tdata[14];
   assign seqi  = req_tdata[30:15];

   logic [kmss_pkg::CFG_W-1:0]  limit_ff, limit_in;
   logic [kmss_pkg::CFG_W-1:0]  lenr_ff, lenr_in;
   logic [kmss_pkg::POS_W-1:0]  cnt_ff, cnt_in;
   logic [kmss_pkg::SEQ_W-1:0]  seq_ff, seq_in;
   logic                        skip_ff, skip_in;
   logic                        elig_ff, elig_in;
   logic [kmss_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic [PD-1:0]               pipe_vld_ff, pipe_vld_in;
   logic                        sweep_ff, sweep_in;
   logic [CW-1:0]               sweep_cnt_ff, sweep_cnt_in;
   logic                        wr_pend_ff, wr_pend_in;
   logic [AW-1:0]               wr_idx_ff, wr_idx_in;
   logic [kmss_pkg::SYMBOL_W-1:0] p_rd_ff;
   logic [kmss_pkg::SYMBOL_W-1:0] p_mem [MAX_PATTERN];
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [kmss_pkg::SEQ_W-1:0]  rsp_seq_ff, rsp_seq_in;
   logic [kmss_pkg::POS_W-1:0]  rsp_pos_ff, rsp_pos_in;
   logic                        park_valid_ff, park_valid_in;

   logic                        busy;
   logic                        req_acc;
   logic                        seq_acc;
   logic                        pat_acc;
   logic [CW-1:0]               len_used;
   logic [kmss_pkg::POS_W-1:0]  cnt_base;
   logic                        cnt_full;
   logic                        slot_in_mem;
   logic                        slot_in_len;
   logic [31:0]                 pat_cell_full;
   logic [AW-1:0]               pat_cell_idx;
   logic [31:0]                 sweep_addr_full;
   logic [AW-1:0]               sweep_addr;
   logic [AW-1:0]               slot_addr;
   logic                        rsp_take;
   logic                        out_free;
   logic                        hit;
   logic [CW-1:0]               tree_sum;

   kmss_pkg::cell_ctl_type      cell_ctl;
   logic [kmss_pkg::SYMBOL_W-1:0] cell_text [MAX_PATTERN];
   logic [MAX_PATTERN-1:0]      cell_we;
   logic [MAX_PATTERN-1:0]      cell_active;
   logic [MAX_PATTERN-1:0]      cell_miss;

   always_comb begin
      if (lenr_ff == '0) begin
         len_used = CW'(1);
      end else if (32'(lenr_ff) > MAX_PATTERN) begin
         len_used = CW'(MAX_PATTERN);
      end else begin
         len_used = CW'(lenr_ff);
      end
   end

   assign busy       = (|pipe_vld_ff) || park_valid_ff || sweep_ff || wr_pend_ff;
   assign req_tready = !busy;
   assign req_acc    = req_tvalid && !busy;
   assign seq_acc    = req_acc && (mode == kmss_pkg::MODE_SEQUENCE);
   assign pat_acc    = req_acc && (mode == kmss_pkg::MODE_PATTERN);
   assign csr_ready  = 1'b1;

   assign slot_in_mem     = 32'(slot) < MAX_PATTERN;
   assign slot_in_len     = 32'(slot) < 32'(len_used);
   assign pat_cell_full   = 32'(len_used) - 32'd1 - 32'(slot);
   assign pat_cell_idx    = pat_cell_full[AW-1:0];
   assign sweep_addr_full = 32'(len_used) - 32'd1 - 32'(sweep_cnt_ff);
   assign sweep_addr      = sweep_addr_full[AW-1:0];
   assign slot_addr       = AW'(slot);

   assign cnt_base = fresh ? '0 : cnt_ff;
   assign cnt_full = (cnt_base == '1);

   assign rsp_take = rsp_valid_ff && rsp_tready;
   assign out_free = !rsp_valid_ff || rsp_take;
   assign hit      = pipe_vld_ff[PD-1] && elig_ff && (32'(tree_sum) <= 32'(limit_ff));

   always_comb begin
      limit_in = limit_ff;
      lenr_in  = lenr_ff;
      if (csr_valid) begin
         unique case (csr_index)
            kmss_pkg::REG_MISMATCH_LIMIT: limit_in = csr_data;
            kmss_pkg::REG_PATTERN_LENGTH: lenr_in  = csr_data;
         endcase
      end
   end

   always_comb begin
      cnt_in  = cnt_ff;
      seq_in  = seq_ff;
      skip_in = skip_ff;
      if (seq_acc) begin
         if (fresh) begin
            seq_in = seqi;
         end
         cnt_in  = cnt_full ? cnt_base : cnt_base + 32'd1;
         skip_in = cnt_full;
      end
      pipe_vld_in = {pipe_vld_ff[PD-2:0], seq_acc};
      elig_in     = elig_ff;
      pos_in      = pos_ff;
      if (pipe_vld_ff[0]) begin
         elig_in = !skip_ff && (32'(len_used) <= cnt_ff);
         pos_in  = cnt_ff - 32'(len_used);
      end
   end

   always_comb begin
      sweep_in     = sweep_ff;
      sweep_cnt_in = sweep_cnt_ff;
      wr_pend_in   = 1'b0;
      wr_idx_in    = wr_idx_ff;
      if (csr_valid && (csr_index == kmss_pkg::REG_PATTERN_LENGTH)) begin
         sweep_in     = 1'b1;
         sweep_cnt_in = '0;
      end else if (sweep_ff) begin
         wr_pend_in   = 1'b1;
         wr_idx_in    = AW'(sweep_cnt_ff);
         sweep_cnt_in = sweep_cnt_ff + CW'(1);
         if ((32'(sweep_cnt_ff) + 32'd1) >= 32'(len_used)) begin
            sweep_in = 1'b0;
         end
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_seq_in    = rsp_seq_ff;
      rsp_pos_in    = rsp_pos_ff;
      park_valid_in = park_valid_ff;
      if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
      if (hit) begin
         if (out_free) begin
            rsp_valid_in = 1'b1;
            rsp_seq_in   = seq_ff;
            rsp_pos_in   = pos_ff;
         end else begin
            park_valid_in = 1'b1;
         end
      end else if (park_valid_ff && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_seq_in    = seq_ff;
         rsp_pos_in    = pos_ff;
         park_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff      <= '0;
         lenr_ff       <= kmss_pkg::CFG_W'(1);
         cnt_ff        <= '0;
         seq_ff        <= '0;
         skip_ff       <= 1'b0;
         pipe_vld_ff   <= '0;
         sweep_ff      <= 1'b0;
         sweep_cnt_ff  <= '0;
         wr_pend_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         park_valid_ff <= 1'b0;
      end else begin
         limit_ff      <= limit_in;
         lenr_ff       <= lenr_in;
         cnt_ff        <= cnt_in;
         seq_ff        <= seq_in;
         skip_ff       <= skip_in;
         pipe_vld_ff   <= pipe_vld_in;
         sweep_ff      <= sweep_in;
         sweep_cnt_ff  <= sweep_cnt_in;
         wr_pend_ff    <= wr_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
         park_valid_ff <= park_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      elig_ff    <= elig_in;
      pos_ff     <= pos_in;
      wr_idx_ff  <= wr_idx_in;
      rsp_seq_ff <= rsp_seq_in;
      rsp_pos_ff <= rsp_pos_in;
   end

   always_ff @(posedge clock) begin
      if (pat_acc && slot_in_mem) begin
         p_mem[slot_addr] <= sym;
      end
      p_rd_ff <= p_mem[sweep_addr];
   end

   assign cell_ctl.shift    = seq_acc;
   assign cell_ctl.pat_data = wr_pend_ff ? p_rd_ff : sym;

   genvar j;
   for (j = 0; j < MAX_PATTERN; j++) begin : g_cell
      logic [kmss_pkg::SYMBOL_W-1:0] text_in;

      if (j == 0) begin : g_head
         assign text_in = sym;
      end else begin : g_link
         assign text_in = cell_text[j-1];
      end

      assign cell_we[j] = (pat_acc && slot_in_len && (32'(pat_cell_idx) == j))
                          || (wr_pend_ff && (32'(wr_idx_ff) == j));
      assign cell_active[j] = j < 32'(len_used);

      kmss_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (cell_ctl),
         .text_in  (text_in),
         .pat_we   (cell_we[j]),
         .active   (cell_active[j]),
         .text_out (cell_text[j]),
         .miss     (cell_miss[j])
      );
   end

   kmss_sum_tree #(
      .N  (MAX_PATTERN),
      .CW (CW)
   ) u_sum_tree (
      .clock (clock),
      .bits  (cell_miss),
      .sum   (tree_sum)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_pos_ff, rsp_seq_ff};

endmodule

`default_nettype wire
